FILE: hdl/so3e_pkg.sv
// ============================================================================
// so3e_pkg: shared types and constants for the SO(3) attitude error block
// Fixed-point widths of the matrix, error and rate paths, plus the gain reset.
// ============================================================================
package so3e_pkg;

    localparam int Q_W     = 16;   // quaternion component, Q1.14
    localparam int SQ_W    = 32;   // product of two components, Q.28
    localparam int QM_W    = 35;   // unrounded matrix entry, Q.28
    localparam int MAT_W   = 22;   // rounded matrix entry, Q.16
    localparam int PROD_W  = 44;   // product of two matrix entries, Q.32
    localparam int DIFF_W  = 46;   // skew difference, Q.32
    localparam int GAIN_W  = 16;   // gain, unsigned Q8.8
    localparam int RATE_W  = 24;   // output rate, Q9.14
    localparam int LO_W    = 23;   // low slice of the difference for the gain multiply
    localparam int HI_W    = DIFF_W - LO_W;
    localparam int HIG_W   = HI_W + GAIN_W + 1;
    localparam int LOG_W   = LO_W + GAIN_W + 2;
    localparam int ACC_W   = 64;
    localparam int MAT_SHIFT = 12;
    localparam int OUT_SHIFT = 27;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd512;

    typedef logic signed [MAT_W-1:0] mat_ent_t;
    typedef mat_ent_t [8:0] mat_t;    // entry (i,j) at index 3*i+j

    typedef struct packed {
        logic signed [Q_W-1:0] z;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] w;
    } quat_t;

    // pipeline control shared by all stage modules
    typedef struct packed {
        logic en;       // advance all stages
        logic valid;    // beat entering the stage module
    } pipe_ctl_t;

endpackage

FILE: hdl/so3_attitude_error_rate.sv
// ============================================================================
// so3_attitude_error_rate: geometric SO(3) attitude error to body rate command
// Six-stage pipeline from an attitude pair to saturated Q9.14 body rates.
// ============================================================================
// Usage:
//   s_axis carries one attitude pair per beat: current quaternion (w,x,y,z)
//   and reference quaternion, all signed Q1.14. m_axis carries one beat of
//   desired body rates (x,y,z), signed Q9.14, saturated to 24 bits.
//   cfg_wr_en/cfg_wr_data load rate_gain (2/tau, unsigned Q8.8); write it
//   only while no beat is in flight.
// Stage chain from input beat to output beat: products, matrix round,
//   entry products, skew sums, gain multiply, round/saturate.
// Throughput: one beat per cycle; the pipeline takes a new pair every cycle
//   while the output side accepts.
// Stall: when m_axis_tready is low with a beat waiting, the whole pipeline
//   holds and s_axis_tready drops, bubbles included; while m_axis_tvalid is
//   low the pipe advances whatever m_axis_tready is, since the last stage
//   register is the output register.
// Reset: rst_n clears all stage valid bits and loads rate_gain with 2.0.
// ============================================================================
module so3_attitude_error_rate
    import so3e_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // cur_w, cur_x, cur_y, cur_z, ref_w, ref_x, ref_y, ref_z (16 bits each)
    input  logic [127:0]         s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // rate_x, rate_y, rate_z (24 bits each)
    output logic [71:0]          m_axis_tdata,
    input  logic                 cfg_wr_en,
    input  logic [GAIN_W-1:0]    cfg_wr_data
);

    logic [GAIN_W-1:0]        gain_reg;
    logic                     pipe_en;
    pipe_ctl_t                ctl_mat;
    pipe_ctl_t                ctl_err;
    pipe_ctl_t                ctl_out;
    quat_t                    cur_q;
    quat_t                    ref_q;
    mat_t                     r_mat;
    mat_t                     rd_mat;
    logic                     mat_valid;
    logic                     err_valid;
    logic signed [DIFF_W-1:0] diff [3];
    logic signed [RATE_W-1:0] rate [3];

    // gain register, written directly from the config port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= GAIN_RESET;
        else if (cfg_wr_en)
            gain_reg <= cfg_wr_data;
    end

    // one enable for all stages: advance unless the output beat is stuck
    assign pipe_en       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = pipe_en;

    assign cur_q = s_axis_tdata[63:0];
    assign ref_q = s_axis_tdata[127:64];

    assign ctl_mat = '{en: pipe_en, valid: s_axis_tvalid};
    assign ctl_err = '{en: pipe_en, valid: mat_valid};
    assign ctl_out = '{en: pipe_en, valid: err_valid};

    // stages 1-2: both rotation matrices
    so3e_mat_stage u_mat (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_mat),
        .cur       (cur_q),
        .ref_q     (ref_q),
        .out_valid (mat_valid),
        .r_mat     (r_mat),
        .rd_mat    (rd_mat)
    );

    // stages 3-4: skew differences of R^T * Rd
    so3e_err_vec u_err (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_err),
        .r_mat     (r_mat),
        .rd_mat    (rd_mat),
        .out_valid (err_valid),
        .diff      (diff)
    );

    // stages 5-6: gain, 0.5 factor, rounding, saturation; stage 6 is the output register
    so3e_rate_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_out),
        .diff      (diff),
        .gain      (gain_reg),
        .out_valid (m_axis_tvalid),
        .rate      (rate)
    );

    assign m_axis_tdata = {rate[2], rate[1], rate[0]};

    // a stalled pipeline keeps every in-flight valid bit
    assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable({mat_valid, err_valid, m_axis_tvalid}))
        else $error("pipeline valid bits moved during a stall");

    // a refused output beat stays up with the same data
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output beat changed while stalled");

    // reset clears the output valid
    assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid set during reset");

endmodule

FILE: hdl/so3e_mat_stage.sv
// ============================================================================
// so3e_mat_stage: quaternion to rotation matrix, two pipeline stages
// Stage 1 squares and cross products, stage 2 builds and rounds the entries.
// ============================================================================
module so3e_mat_stage
    import so3e_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  pipe_ctl_t ctl,
    input  quat_t     cur,
    input  quat_t     ref_q,
    output logic      out_valid,
    output mat_t      r_mat,
    output mat_t      rd_mat
);

    localparam logic signed [QM_W-1:0] ONE_Q28 = QM_W'(1) <<< 28;
    localparam logic signed [QM_W-1:0] HALF_LSB = QM_W'(1) <<< (MAT_SHIFT - 1);

    // product order: xx yy zz xy xz yz wx wy wz
    typedef logic signed [SQ_W-1:0] sq_t;

    sq_t  pc_reg [9];
    sq_t  pr_reg [9];
    logic v1_reg;
    logic v2_reg;
    mat_t r_reg;
    mat_t rd_reg;

    function automatic mat_ent_t rnd(input logic signed [QM_W-1:0] v);
        logic signed [QM_W-1:0] s;
        s = v + HALF_LSB;
        return s[MAT_SHIFT+MAT_W-1:MAT_SHIFT];
    endfunction

    function automatic mat_ent_t diag_ent(input sq_t a, input sq_t b);
        logic signed [QM_W-1:0] s;
        s = ONE_Q28 - ((QM_W'(a) + QM_W'(b)) <<< 1);
        return rnd(s);
    endfunction

    function automatic mat_ent_t off_ent(input sq_t a, input sq_t b, input logic sub);
        logic signed [QM_W-1:0] s;
        s = sub ? (QM_W'(a) - QM_W'(b)) : (QM_W'(a) + QM_W'(b));
        return rnd(s <<< 1);
    endfunction

    function automatic mat_t build(input sq_t p [9]);
        mat_t m;
        m[0] = diag_ent(p[1], p[2]);
        m[1] = off_ent(p[3], p[8], 1'b1);
        m[2] = off_ent(p[4], p[7], 1'b0);
        m[3] = off_ent(p[3], p[8], 1'b0);
        m[4] = diag_ent(p[0], p[2]);
        m[5] = off_ent(p[5], p[6], 1'b1);
        m[6] = off_ent(p[4], p[7], 1'b1);
        m[7] = off_ent(p[5], p[6], 1'b0);
        m[8] = diag_ent(p[0], p[1]);
        return m;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            pc_reg[0] <= cur.x * cur.x;
            pc_reg[1] <= cur.y * cur.y;
            pc_reg[2] <= cur.z * cur.z;
            pc_reg[3] <= cur.x * cur.y;
            pc_reg[4] <= cur.x * cur.z;
            pc_reg[5] <= cur.y * cur.z;
            pc_reg[6] <= cur.w * cur.x;
            pc_reg[7] <= cur.w * cur.y;
            pc_reg[8] <= cur.w * cur.z;
            pr_reg[0] <= ref_q.x * ref_q.x;
            pr_reg[1] <= ref_q.y * ref_q.y;
            pr_reg[2] <= ref_q.z * ref_q.z;
            pr_reg[3] <= ref_q.x * ref_q.y;
            pr_reg[4] <= ref_q.x * ref_q.z;
            pr_reg[5] <= ref_q.y * ref_q.z;
            pr_reg[6] <= ref_q.w * ref_q.x;
            pr_reg[7] <= ref_q.w * ref_q.y;
            pr_reg[8] <= ref_q.w * ref_q.z;
            r_reg     <= build(pc_reg);
            rd_reg    <= build(pr_reg);
        end
    end

    assign out_valid = v2_reg;
    assign r_mat     = r_reg;
    assign rd_mat    = rd_reg;

endmodule

FILE: hdl/so3e_err_vec.sv
// ============================================================================
// so3e_err_vec: skew part of R^T * Rd, two pipeline stages
// Stage 3 registers the 18 entry products, stage 4 sums them per axis.
// ============================================================================
module so3e_err_vec
    import so3e_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pipe_ctl_t                ctl,
    input  mat_t                     r_mat,
    input  mat_t                     rd_mat,
    output logic                     out_valid,
    output logic signed [DIFF_W-1:0] diff [3]
);

    // axis a: sum over k of r[k][A]*rd[k][B] - r[k][B]*rd[k][A]
    localparam int COL_A [3] = '{2, 0, 1};
    localparam int COL_B [3] = '{1, 2, 0};

    logic signed [PROD_W-1:0] prod_reg [3][3][2];
    logic signed [DIFF_W-1:0] diff_reg [3];
    logic signed [DIFF_W-1:0] diff_next [3];
    logic                     v3_reg;
    logic                     v4_reg;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff_next[a] = '0;
            for (int k = 0; k < 3; k++)
            begin
                diff_next[a] = diff_next[a] + DIFF_W'(prod_reg[a][k][0])
                                            - DIFF_W'(prod_reg[a][k][1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v3_reg <= ctl.valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[a][k][0] <= $signed(r_mat[k*3+COL_A[a]])
                                       * $signed(rd_mat[k*3+COL_B[a]]);
                    prod_reg[a][k][1] <= $signed(r_mat[k*3+COL_B[a]])
                                       * $signed(rd_mat[k*3+COL_A[a]]);
                end
                diff_reg[a] <= diff_next[a];
            end
        end
    end

    assign out_valid = v4_reg;
    assign diff      = diff_reg;

endmodule

FILE: hdl/so3e_rate_scale.sv
// ============================================================================
// so3e_rate_scale: gain multiply, rounding and saturation, two pipeline stages
// Stage 5 splits each difference in two slices times the gain, stage 6 merges.
// ============================================================================
module so3e_rate_scale
    import so3e_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  pipe_ctl_t                ctl,
    input  logic signed [DIFF_W-1:0] diff [3],
    input  logic [GAIN_W-1:0]        gain,
    output logic                     out_valid,
    output logic signed [RATE_W-1:0] rate [3]
);

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< (OUT_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX  = ACC_W'((1 << (RATE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MIN  = -(ACC_W'(1) <<< (RATE_W - 1));

    logic signed [HIG_W-1:0]  hig_reg [3];
    logic signed [LOG_W-1:0]  log_reg [3];
    logic signed [RATE_W-1:0] rate_reg [3];
    logic signed [RATE_W-1:0] rate_next [3];
    logic signed [GAIN_W:0]   gain_s;
    logic                     v5_reg;
    logic                     v6_reg;

    assign gain_s = $signed({1'b0, gain});

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            logic signed [ACC_W-1:0] acc;
            logic signed [ACC_W-1:0] val;
            acc = (ACC_W'(hig_reg[a]) <<< LO_W) + ACC_W'(log_reg[a]) + RND_HALF;
            val = acc >>> OUT_SHIFT;
            if (val > SAT_MAX)
                rate_next[a] = SAT_MAX[RATE_W-1:0];
            else if (val < SAT_MIN)
                rate_next[a] = SAT_MIN[RATE_W-1:0];
            else
                rate_next[a] = val[RATE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v5_reg <= ctl.valid;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                hig_reg[a]  <= $signed(diff[a][DIFF_W-1:LO_W]) * gain_s;
                log_reg[a]  <= $signed({1'b0, diff[a][LO_W-1:0]}) * gain_s;
                rate_reg[a] <= rate_next[a];
            end
        end
    end

    assign out_valid = v6_reg;
    assign rate      = rate_reg;

endmodule
